// ----- rtl/dpa_pkg.sv -----
// Shared types and constants for the duplex pump alternator.
package dpa_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_ALT_LIMIT     = 2'd0,
    CFG_SAVE_INTERVAL = 2'd1,
    CFG_ACID_PERIOD   = 2'd2
  } dpa_cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ALT     = 3'd1,
    MODE_RESERVE = 3'd2,
    MODE_FAILED  = 3'd3,
    MODE_MANUAL  = 3'd4
  } dpa_mode_e;

  localparam logic [CNT_W-1:0] ALT_LIMIT_RST     = 16'd30;
  localparam logic [CNT_W-1:0] SAVE_INTERVAL_RST = 16'd20;
  localparam logic [CNT_W-1:0] ACID_PERIOD_RST   = 16'd10;

  // Effective limits, each already forced to at least one.
  typedef struct packed {
    logic [CNT_W-1:0] alt_limit;
    logic [CNT_W-1:0] save_interval;
    logic [CNT_W-1:0] acid_period;
  } dpa_cfg_t;

  typedef struct packed {
    logic run;
    logic ready;
  } dpa_chan_in_t;

  typedef struct packed {
    logic kick;
    logic pend_set;
    logic save;
  } dpa_chan_out_t;

  typedef struct packed {
    logic       line_is_380v;
    logic [2:0] p1_phase_faults;
    logic [2:0] p2_phase_faults;
    logic       p1_overheat;
    logic       p2_overheat;
    logic       power_switch_on;
    logic       manual_mode;
    logic       p1_run_cmd;
    logic       p2_run_cmd;
  } dpa_tick_t;

  typedef struct packed {
    logic      relay_one;
    logic      relay_two;
    logic      relay_alarm;
    logic      lamp_p1_run;
    logic      lamp_p1_fault;
    logic      lamp_p2_run;
    logic      lamp_p2_fault;
    dpa_mode_e mode;
    logic      lead_is_one;
    logic      save_request;
  } dpa_result_t;

endpackage

// ----- rtl/dpa_cfg_regs.sv -----
// Configuration register file: change time, save interval, exercise period.
module dpa_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [dpa_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [dpa_pkg::CNT_W-1:0]            cfg_data_i,
  output dpa_pkg::dpa_cfg_t                    cfg_o
);

  dpa_pkg::dpa_cfg_t        cfg_d, cfg_q;
  logic [dpa_pkg::CNT_W-1:0] val_eff;

  // A zero limit behaves as one; store it that way.
  assign val_eff = (cfg_data_i == '0) ? dpa_pkg::CNT_W'(1) : cfg_data_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        dpa_pkg::CFG_ALT_LIMIT:     cfg_d.alt_limit     = val_eff;
        dpa_pkg::CFG_SAVE_INTERVAL: cfg_d.save_interval = val_eff;
        dpa_pkg::CFG_ACID_PERIOD:   cfg_d.acid_period   = val_eff;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt_limit     <= dpa_pkg::ALT_LIMIT_RST;
      cfg_q.save_interval <= dpa_pkg::SAVE_INTERVAL_RST;
      cfg_q.acid_period   <= dpa_pkg::ACID_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dpa_pump_chan.sv -----
// Per-pump run, save-phase, idle and exercise-kick counters.
module dpa_pump_chan #(
  parameter int unsigned KickTicks = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  dpa_pkg::dpa_chan_in_t ctl_i,
  input  dpa_pkg::dpa_cfg_t     cfg_i,
  output dpa_pkg::dpa_chan_out_t out_o
);

  localparam logic [1:0] KickLoad = 2'(KickTicks - 1);

  logic [dpa_pkg::CNT_W-1:0] rc_d, rc_q, sp_d, sp_q, ic_d, ic_q;
  logic [1:0]                kl_d, kl_q;
  logic [dpa_pkg::CNT_W:0]   sp_inc;
  logic [dpa_pkg::CNT_W-1:0] rc_wrap, rc_next, ic_inc;
  logic                      rc_hit, sp_hit, ic_hit, sp_zero;

  assign rc_wrap = rc_q + dpa_pkg::CNT_W'(1);
  assign rc_hit  = rc_wrap >= cfg_i.alt_limit;
  assign rc_next = rc_hit ? '0 : rc_wrap;
  assign sp_inc  = {1'b0, sp_q} + (dpa_pkg::CNT_W + 1)'(1);
  assign sp_hit  = sp_inc >= {1'b0, cfg_i.save_interval};
  assign sp_zero = (rc_next == '0) || sp_hit;
  assign ic_inc  = ic_q + dpa_pkg::CNT_W'(1);
  assign ic_hit  = ic_inc >= cfg_i.acid_period;

  always_comb begin
    rc_d  = rc_q;
    sp_d  = sp_q;
    ic_d  = ic_q;
    kl_d  = kl_q;
    out_o = '0;
    if (ctl_i.run) begin
      rc_d           = rc_next;
      sp_d           = sp_zero ? '0 : sp_inc[dpa_pkg::CNT_W-1:0];
      ic_d           = '0;
      kl_d           = '0;
      out_o.pend_set = rc_hit;
      out_o.save     = sp_zero;
    end else if (!ctl_i.ready) begin
      ic_d = '0;
      kl_d = '0;
    end else if (kl_q != '0) begin
      kl_d       = kl_q - 2'd1;
      out_o.kick = 1'b1;
    end else begin
      ic_d = ic_hit ? '0 : ic_inc;
      if (ic_hit) begin
        kl_d       = KickLoad;
        out_o.kick = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      sp_q <= '0;
      ic_q <= '0;
      kl_q <= '0;
    end else if (step_i) begin
      rc_q <= rc_d;
      sp_q <= sp_d;
      ic_q <= ic_d;
      kl_q <= kl_d;
    end
  end

endmodule

// ----- rtl/duplex_pump_alternator_unit.sv -----
// Registered path from input transaction to result: input register, then result register.
// Throughput: one tick per cycle while the result side does not stall; the pump state updates in the single step stage.
// Stall on the result side backs up through the input register combinationally.
// Reset: all control and pump state cleared, limits to 30 / 20 / 10, pump two leads.
// Configuration writes are taken every cycle (ready held high).
module duplex_pump_alternator_unit #(
  parameter int unsigned KICK_TICKS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpa_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [dpa_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          line_is_380v_i,
  input  logic [2:0]                    p1_phase_faults_i,
  input  logic [2:0]                    p2_phase_faults_i,
  input  logic                          p1_overheat_i,
  input  logic                          p2_overheat_i,
  input  logic                          power_switch_on_i,
  input  logic                          manual_mode_i,
  input  logic                          p1_run_cmd_i,
  input  logic                          p2_run_cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          relay_one_o,
  output logic                          relay_two_o,
  output logic                          relay_alarm_o,
  output logic                          lamp_p1_run_o,
  output logic                          lamp_p1_fault_o,
  output logic                          lamp_p2_run_o,
  output logic                          lamp_p2_fault_o,
  output logic [2:0]                    mode_o,
  output logic                          lead_is_one_o,
  output logic                          save_request_o
);

  dpa_pkg::dpa_cfg_t      cfg;
  dpa_pkg::dpa_tick_t     in_q;
  dpa_pkg::dpa_result_t   res, out_q;
  dpa_pkg::dpa_chan_in_t  ctl [2];
  dpa_pkg::dpa_chan_out_t chan [2];

  logic       in_valid_q, out_valid_q;
  logic       in_load, adv, step;
  logic [1:0] ready_d, ready_q, fsl_d, fsl_q, now, run, fault_lamp;
  logic       lead_d, lead_q, pend_d, pend_q;
  dpa_pkg::dpa_mode_e mode;

  assign cfg_ready_o = 1'b1;

  dpa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the result register frees when empty or taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= '{line_is_380v:    line_is_380v_i,
                p1_phase_faults: p1_phase_faults_i,
                p2_phase_faults: p2_phase_faults_i,
                p1_overheat:     p1_overheat_i,
                p2_overheat:     p2_overheat_i,
                power_switch_on: power_switch_on_i,
                manual_mode:     manual_mode_i,
                p1_run_cmd:      p1_run_cmd_i,
                p2_run_cmd:      p2_run_cmd_i};
    end
  end

  // Fault seen this tick: overheat, plus any phase bit on a three-phase line.
  assign now[0] = in_q.p1_overheat | (in_q.line_is_380v & (|in_q.p1_phase_faults));
  assign now[1] = in_q.p2_overheat | (in_q.line_is_380v & (|in_q.p2_phase_faults));

  always_comb begin
    ready_d    = '0;
    fsl_d      = '0;
    run        = '0;
    fault_lamp = '0;
    mode       = dpa_pkg::MODE_OFF;
    lead_d     = lead_q;
    pend_d     = pend_q;
    if (in_q.power_switch_on) begin
      ready_d = ~(now & fsl_q);
      fsl_d   = now;
      if (&ready_d) begin
        if (in_q.manual_mode) begin
          mode = dpa_pkg::MODE_MANUAL;
          run  = {in_q.p2_run_cmd, in_q.p1_run_cmd};
        end else begin
          mode = dpa_pkg::MODE_ALT;
          if (pend_q) begin
            lead_d = ~lead_q;
            pend_d = 1'b0;
          end
          run = {~lead_d, lead_d};
        end
      end else if (|ready_d) begin
        mode       = dpa_pkg::MODE_RESERVE;
        run        = ready_d;
        fault_lamp = ~ready_d;
      end else begin
        mode       = dpa_pkg::MODE_FAILED;
        fault_lamp = 2'b11;
      end
    end
    // Set a pending change when either pump's run counter reaches the change limit this tick.
    if (chan[0].pend_set || chan[1].pend_set) begin
      pend_d = 1'b1;
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_chan
    assign ctl[p].run   = run[p];
    assign ctl[p].ready = ready_d[p];

    dpa_pump_chan #(
      .KickTicks (KICK_TICKS)
    ) u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .ctl_i  (ctl[p]),
      .cfg_i  (cfg),
      .out_o  (chan[p])
    );
  end

  always_comb begin
    res.relay_one     = run[0] | chan[0].kick;
    res.relay_two     = run[1] | chan[1].kick;
    res.relay_alarm   = (mode == dpa_pkg::MODE_FAILED);
    res.lamp_p1_run   = run[0] | chan[0].kick;
    res.lamp_p1_fault = fault_lamp[0] & ~chan[0].kick;
    res.lamp_p2_run   = run[1] | chan[1].kick;
    res.lamp_p2_fault = fault_lamp[1] & ~chan[1].kick;
    res.mode          = mode;
    res.lead_is_one   = lead_d;
    res.save_request  = chan[0].save | chan[1].save;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= '0;
      fsl_q       <= '0;
      lead_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        ready_q <= ready_d;
        fsl_q   <= fsl_d;
        lead_q  <= lead_d;
        pend_q  <= pend_d;
      end
      if (adv) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign relay_one_o     = out_q.relay_one;
  assign relay_two_o     = out_q.relay_two;
  assign relay_alarm_o   = out_q.relay_alarm;
  assign lamp_p1_run_o   = out_q.lamp_p1_run;
  assign lamp_p1_fault_o = out_q.lamp_p1_fault;
  assign lamp_p2_run_o   = out_q.lamp_p2_run;
  assign lamp_p2_fault_o = out_q.lamp_p2_fault;
  assign mode_o          = out_q.mode;
  assign lead_is_one_o   = out_q.lead_is_one;
  assign save_request_o  = out_q.save_request;

`ifndef NO_ASSERTIONS
  a_alarm_no_relay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relay_alarm_o |-> !relay_one_o && !relay_two_o
      && mode_o == dpa_pkg::MODE_FAILED)
    else $error("alarm with a pump relay driven");

  a_off_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == dpa_pkg::MODE_OFF |-> !relay_one_o && !relay_two_o
      && !save_request_o && !lamp_p1_fault_o && !lamp_p2_fault_o)
    else $error("output active while powered off");

  a_lamp_follows_relay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lamp_p1_run_o == relay_one_o && lamp_p2_run_o == relay_two_o)
    else $error("run lamp differs from relay");

  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input accepted over a held tick");

  a_state_only_on_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(lead_q) && $stable(pend_q) && $stable(ready_q))
    else $error("pump state changed without a tick");
`endif

endmodule
